// ===== hdl/aepc_pkg.sv =====
// Package for the proportional auto-exposure controller.
// Holds the window constant, configuration layout, queue item type and reset values.
// No dependencies; imported by every module of the block.
package aepc_pkg;

    // Samples summed per window (one extra leading sample is skipped)
    localparam int unsigned WINDOW_RUNS = 8;
    localparam int unsigned CNT_W       = $clog2(WINDOW_RUNS + 1);
    localparam int unsigned TOTAL_W     = CNT_W + 2;

    // Field widths
    localparam int unsigned BRIGHT_W = 12;
    localparam int unsigned EXPO_W   = 16;
    localparam int unsigned HYST_W   = 15;
    localparam int unsigned GAIN_W   = 8;
    localparam int unsigned ERR_W    = BRIGHT_W + 1;
    localparam int unsigned SUM_W    = 17;
    localparam int unsigned PROD_W   = SUM_W + GAIN_W + 1;
    localparam int unsigned NEWX_W   = PROD_W + 1;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT_LOW    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT_HIGH   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT_TARGET = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS    = 8'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN          = 8'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPO_MIN      = 8'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPO_MAX      = 8'd6;

    localparam logic [BRIGHT_W-1:0] RST_BRIGHT_LOW    = 12'd200;
    localparam logic [BRIGHT_W-1:0] RST_BRIGHT_HIGH   = 12'd2000;
    localparam logic [BRIGHT_W-1:0] RST_BRIGHT_TARGET = 12'd500;
    localparam logic [HYST_W-1:0]   RST_HYSTERESIS    = 15'd10;
    localparam logic [GAIN_W-1:0]   RST_GAIN          = 8'd2;
    localparam logic [EXPO_W-1:0]   RST_EXPO_MIN      = 16'd0;
    localparam logic [EXPO_W-1:0]   RST_EXPO_MAX      = 16'd65535;

    // Queue depth between front and back
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [BRIGHT_W-1:0] bright_low;
        logic [BRIGHT_W-1:0] bright_high;
        logic [BRIGHT_W-1:0] bright_target;
        logic [HYST_W-1:0]   hysteresis;
        logic [GAIN_W-1:0]   gain;
        logic [EXPO_W-1:0]   expo_min;
        logic [EXPO_W-1:0]   expo_max;
    } t_cfg;

    // Accumulate into the window sum, or add and close the window
    typedef enum logic {
        KIND_ACC   = 1'b0,
        KIND_CLOSE = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind                    kind;
        logic                     once;
        logic [EXPO_W-1:0]        expo;
        logic signed [ERR_W-1:0]  err;
    } t_item;

endpackage

// ===== hdl/aepc_front.sv =====
// Front end of the auto-exposure controller: accepts input beats,
// drops in-band frames unless once-mode is set, tracks the window position and queues the work.
// Depends on aepc_pkg.
module aepc_front
    import aepc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [BRIGHT_W-1:0] i_bright,
    input  logic                i_once,
    input  logic [EXPO_W-1:0]   i_expo,
    input  t_cfg                i_cfg,
    input  logic                i_q_full,
    output logic                o_ready,
    output logic                o_push,
    output t_item               o_item
);

    logic [CNT_W-1:0] r_window;
    logic [CNT_W-1:0] n_window;
    logic             beat;
    logic             active;
    logic             skip;

    // Classify the beat
    assign o_ready = !i_q_full;
    assign beat    = i_valid && o_ready;
    assign active  = (i_bright < i_cfg.bright_low) || (i_bright > i_cfg.bright_high) || i_once;
    assign skip    = (r_window == CNT_W'(WINDOW_RUNS));
    assign o_push  = beat && active && !skip;

    // Build the queue item
    always_comb begin
        o_item.kind = (r_window == '0) ? KIND_CLOSE : KIND_ACC;
        o_item.once = i_once;
        o_item.expo = i_expo;
        o_item.err  = $signed({1'b0, i_cfg.bright_target}) - $signed({1'b0, i_bright});
    end

    // Advance the window position on active beats
    always_comb begin
        n_window = r_window;
        if (beat && active) begin
            if (r_window == '0) begin
                n_window = CNT_W'(WINDOW_RUNS);
            end else begin
                n_window = r_window - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= CNT_W'(WINDOW_RUNS);
        end else begin
            r_window <= n_window;
        end
    end

endmodule

// ===== hdl/aepc_queue.sv =====
// Short FIFO between the front end and the back end of the controller.
// Depends on aepc_pkg for the item type and depth.
module aepc_queue
    import aepc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item,
    output logic  o_full
);

    t_item              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic               do_push;
    logic               do_pop;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Move pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/aepc_back.sv =====
// Back end of the auto-exposure controller: sums window errors, applies the
// gain, clamps the exposure, tracks stability and holds the output beat.
// Depends on aepc_pkg.
module aepc_back
    import aepc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  t_item             i_q_item,
    input  t_cfg              i_cfg,
    input  logic              i_out_ready,
    output logic              o_pop,
    output logic              o_out_valid,
    output logic [EXPO_W-1:0] o_new_expo,
    output logic              o_status,
    output logic              o_once_fin
);

    // Window sum and stability state
    logic signed [SUM_W-1:0]  r_err_sum;
    logic [CNT_W-1:0]         r_stable;

    // Stage 1: closed window sum
    logic                     r_s1_v;
    logic signed [SUM_W-1:0]  r_s1_sum;
    logic [EXPO_W-1:0]        r_s1_expo;
    logic                     r_s1_once;

    // Stage 2: scaled correction
    logic                     r_s2_v;
    logic signed [PROD_W-1:0] r_s2_prod;
    logic                     r_s2_big;
    logic [EXPO_W-1:0]        r_s2_expo;
    logic                     r_s2_once;

    // Output register
    logic                     r_o_v;
    logic [EXPO_W-1:0]        r_o_expo;
    logic                     r_o_status;
    logic                     r_o_fin;

    logic                     out_free;
    logic                     s2_free;
    logic                     s1_free;
    logic                     s1_adv;
    logic                     s2_adv;
    logic                     pop_acc;
    logic                     pop_close;
    logic signed [SUM_W-1:0]  sum_next;
    logic signed [SUM_W:0]    sum_ext;
    logic signed [SUM_W:0]    hyst_ext;
    logic                     big;
    logic signed [PROD_W-1:0] prod;
    logic signed [NEWX_W-1:0] raw_expo;
    logic signed [NEWX_W-1:0] max_ext;
    logic signed [NEWX_W-1:0] min_ext;
    logic [EXPO_W-1:0]        clamp_expo;
    logic                     hit_hi;
    logic                     hit_lo;
    logic [TOTAL_W-1:0]       total;
    logic                     done;

    // Pipeline flow: each stage moves when the next one is free
    assign out_free  = !r_o_v || i_out_ready;
    assign s2_adv    = r_s2_v && out_free;
    assign s2_free   = !r_s2_v || out_free;
    assign s1_adv    = r_s1_v && s2_free;
    assign s1_free   = !r_s1_v || s2_free;
    assign o_pop     = i_q_valid && ((i_q_item.kind == KIND_ACC) || s1_free);
    assign pop_acc   = o_pop && (i_q_item.kind == KIND_ACC);
    assign pop_close = o_pop && (i_q_item.kind == KIND_CLOSE);
    assign sum_next  = r_err_sum + SUM_W'(i_q_item.err);

    // Dead band test and gain on the closed sum
    assign sum_ext  = (SUM_W + 1)'(r_s1_sum);
    assign hyst_ext = $signed({{(SUM_W + 1 - HYST_W){1'b0}}, i_cfg.hysteresis});
    assign big      = (sum_ext > hyst_ext) || (sum_ext < -hyst_ext);
    assign prod     = $signed({1'b0, i_cfg.gain}) * r_s1_sum;

    // Apply correction and clamp, upper limit first
    always_comb begin
        raw_expo = $signed({{(NEWX_W - EXPO_W){1'b0}}, r_s2_expo});
        if (r_s2_big) begin
            raw_expo = raw_expo + NEWX_W'(r_s2_prod);
        end
        max_ext    = $signed({{(NEWX_W - EXPO_W){1'b0}}, i_cfg.expo_max});
        min_ext    = $signed({{(NEWX_W - EXPO_W){1'b0}}, i_cfg.expo_min});
        hit_hi     = raw_expo > max_ext;
        clamp_expo = hit_hi ? i_cfg.expo_max : raw_expo[EXPO_W-1:0];
        // Compare at full signed width so a negative sum still hits the floor
        hit_lo     = (hit_hi ? max_ext : raw_expo) < min_ext;
        if (hit_lo) begin
            clamp_expo = i_cfg.expo_min;
        end
        total = TOTAL_W'(r_stable) + TOTAL_W'(!r_s2_big) + TOTAL_W'(hit_hi)
              + TOTAL_W'(hit_lo);
        done  = total > TOTAL_W'(WINDOW_RUNS);
    end

    // Window sum accumulation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_sum <= '0;
        end else if (pop_close) begin
            r_err_sum <= '0;
        end else if (pop_acc) begin
            r_err_sum <= sum_next;
        end
    end

    // Stage valids, stability count and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v   <= 1'b0;
            r_s2_v   <= 1'b0;
            r_o_v    <= 1'b0;
            r_stable <= '0;
        end else begin
            if (pop_close) begin
                r_s1_v <= 1'b1;
            end else if (s1_adv) begin
                r_s1_v <= 1'b0;
            end
            if (s1_adv) begin
                r_s2_v <= 1'b1;
            end else if (s2_adv) begin
                r_s2_v <= 1'b0;
            end
            if (s2_adv) begin
                r_o_v    <= 1'b1;
                r_stable <= done ? '0 : CNT_W'(total);
            end else if (i_out_ready) begin
                r_o_v <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (pop_close) begin
            r_s1_sum  <= sum_next;
            r_s1_expo <= i_q_item.expo;
            r_s1_once <= i_q_item.once;
        end
        if (s1_adv) begin
            r_s2_prod <= prod;
            r_s2_big  <= big;
            r_s2_expo <= r_s1_expo;
            r_s2_once <= r_s1_once;
        end
        if (s2_adv) begin
            r_o_expo   <= clamp_expo;
            r_o_status <= done;
            r_o_fin    <= done && r_s2_once;
        end
    end

    assign o_out_valid = r_o_v;
    assign o_new_expo  = r_o_expo;
    assign o_status    = r_o_status;
    assign o_once_fin  = r_o_fin;

endmodule

// ===== hdl/auto_exposure_p_control.sv =====
// Proportional auto-exposure controller. Takes one beat per cycle on the input
// stream while the queue has room; frames whose brightness is inside the accepted
// band are dropped unless once-mode is set. Each window skips its first active
// frame, sums the next WINDOW_RUNS errors and emits one output beat with the last
// of them, carrying the clamped exposure and the done flags. A queue of four
// entries parts the front end from a three-register back end (sum, gain multiply,
// clamp and output register); a result passes the queue and then these registers
// in order. The input keeps taking one beat per cycle while the output is stalled,
// until the queue fills. Configuration writes take effect on the next cycle.
// Depends on aepc_pkg, aepc_front, aepc_queue and aepc_back.
module auto_exposure_p_control
    import aepc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [31:0]           s_axis_tdata,  // [11:0] avg_brightness, [27:12] current_exposure
    input  logic [0:0]            s_axis_tuser,  // [0] once_mode
    // Output stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [15:0]           m_axis_tdata,  // [15:0] new_exposure
    output logic [1:0]            m_axis_tuser   // [0] status, [1] once_finished
);

    t_cfg              r_cfg;
    logic              q_full;
    logic              q_push;
    t_item             q_in;
    logic              q_pop;
    logic              q_valid;
    t_item             q_out;
    logic [EXPO_W-1:0] new_expo;
    logic              status;
    logic              once_fin;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bright_low    <= RST_BRIGHT_LOW;
            r_cfg.bright_high   <= RST_BRIGHT_HIGH;
            r_cfg.bright_target <= RST_BRIGHT_TARGET;
            r_cfg.hysteresis    <= RST_HYSTERESIS;
            r_cfg.gain          <= RST_GAIN;
            r_cfg.expo_min      <= RST_EXPO_MIN;
            r_cfg.expo_max      <= RST_EXPO_MAX;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BRIGHT_LOW:    r_cfg.bright_low    <= i_cfg_data[BRIGHT_W-1:0];
                CFG_BRIGHT_HIGH:   r_cfg.bright_high   <= i_cfg_data[BRIGHT_W-1:0];
                CFG_BRIGHT_TARGET: r_cfg.bright_target <= i_cfg_data[BRIGHT_W-1:0];
                CFG_HYSTERESIS:    r_cfg.hysteresis    <= i_cfg_data[HYST_W-1:0];
                CFG_GAIN:          r_cfg.gain          <= i_cfg_data[GAIN_W-1:0];
                CFG_EXPO_MIN:      r_cfg.expo_min      <= i_cfg_data[EXPO_W-1:0];
                CFG_EXPO_MAX:      r_cfg.expo_max      <= i_cfg_data[EXPO_W-1:0];
                default: begin
                end
            endcase
        end
    end

    aepc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_bright (s_axis_tdata[BRIGHT_W-1:0]),
        .i_once   (s_axis_tuser[0]),
        .i_expo   (s_axis_tdata[BRIGHT_W+EXPO_W-1:BRIGHT_W]),
        .i_cfg    (r_cfg),
        .i_q_full (q_full),
        .o_ready  (s_axis_tready),
        .o_push   (q_push),
        .o_item   (q_in)
    );

    aepc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_out),
        .o_full  (q_full)
    );

    aepc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_item    (q_out),
        .i_cfg       (r_cfg),
        .i_out_ready (m_axis_tready),
        .o_pop       (q_pop),
        .o_out_valid (m_axis_tvalid),
        .o_new_expo  (new_expo),
        .o_status    (status),
        .o_once_fin  (once_fin)
    );

    assign m_axis_tdata = new_expo;
    assign m_axis_tuser = {once_fin, status};

endmodule

// ===== tb/tb_auto_exposure_p_control.sv =====
// Testbench for auto_exposure_p_control: streams frame beats through the block and
// checks every output beat against an in-bench prediction of the exposure loop.
// Depends on aepc_pkg and the auto_exposure_p_control RTL.
module tb_auto_exposure_p_control;
    import aepc_pkg::*;

    localparam int unsigned DRAIN_CYCLES = 16;

    typedef enum {
        FRAME_IGNORED,
        FRAME_SUMMED,
        FRAME_CLOSED
    } t_frame_effect;

    typedef struct packed {
        logic [EXPO_W-1:0] exposure;
        logic              status;
        logic              once_finished;
    } t_expo_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [31:0]           s_axis_tdata = '0;  // [11:0] avg_brightness, [27:12] current_exposure
    logic [0:0]            s_axis_tuser = '0;  // [0] once_mode
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [15:0]           m_axis_tdata;       // [15:0] new_exposure
    logic [1:0]            m_axis_tuser;       // [0] status, [1] once_finished

    // Predicted loop state and register copy
    t_cfg        model_cfg;
    int unsigned frames_left;
    int          window_err_sum;
    int unsigned stable_windows;

    t_expo_result pending_results[$];
    t_expo_result oldest_result;
    bit           failed = 1'b0;
    int unsigned  send_gap_pct = 0;
    int unsigned  stall_pct = 0;

    auto_exposure_p_control i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 i_clk = ~i_clk;

    // Stall the output side at random
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Compare each output beat with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual exposure %0d status %0d",
                         $time, m_axis_tdata, m_axis_tuser[0]);
                failed = 1'b1;
            end else begin
                oldest_result = pending_results.pop_front();
                check_field("new_exposure", oldest_result.exposure, m_axis_tdata);
                check_field("status", oldest_result.status, m_axis_tuser[0]);
                check_field("once_finished", oldest_result.once_finished, m_axis_tuser[1]);
            end
        end
    end

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            failed = 1'b1;
        end
    endtask

    function automatic void reset_loop_model();
        model_cfg.bright_low    = RST_BRIGHT_LOW;
        model_cfg.bright_high   = RST_BRIGHT_HIGH;
        model_cfg.bright_target = RST_BRIGHT_TARGET;
        model_cfg.hysteresis    = RST_HYSTERESIS;
        model_cfg.gain          = RST_GAIN;
        model_cfg.expo_min      = RST_EXPO_MIN;
        model_cfg.expo_max      = RST_EXPO_MAX;
        frames_left    = WINDOW_RUNS;
        window_err_sum = 0;
        stable_windows = 0;
    endfunction

    // Advance the loop by one frame; fill res when the frame closes a window
    function automatic t_frame_effect predict_frame(input logic [BRIGHT_W-1:0] bright,
                                                    input logic once,
                                                    input logic [EXPO_W-1:0] expo_in,
                                                    output t_expo_result res);
        int          expo;
        int          hyst;
        int unsigned bumps;
        int unsigned total;
        bit          done;
        res   = '0;
        expo  = int'(expo_in);
        hyst  = int'(model_cfg.hysteresis);
        bumps = 0;
        if (!(bright < model_cfg.bright_low || bright > model_cfg.bright_high || once))
            return FRAME_IGNORED;
        // The leading frame of a window is skipped
        if (frames_left != WINDOW_RUNS)
            window_err_sum += int'(model_cfg.bright_target) - int'(bright);
        if (frames_left != 0) begin
            frames_left--;
            return FRAME_SUMMED;
        end
        if (window_err_sum > hyst || window_err_sum < -hyst)
            expo += int'(model_cfg.gain) * window_err_sum;
        else
            bumps++;
        // Upper clamp first, then lower; each clamp counts as a stable window
        if (expo > int'(model_cfg.expo_max)) begin
            expo = int'(model_cfg.expo_max);
            bumps++;
        end
        if (expo < int'(model_cfg.expo_min)) begin
            expo = int'(model_cfg.expo_min);
            bumps++;
        end
        frames_left    = WINDOW_RUNS;
        window_err_sum = 0;
        total          = stable_windows + bumps;
        done           = (total > WINDOW_RUNS);
        stable_windows = done ? 0 : (total & 4'hF);
        res.exposure      = expo[EXPO_W-1:0];
        res.status        = done;
        res.once_finished = done && once;
        return FRAME_CLOSED;
    endfunction

    // Send one frame beat, idling first at random, and book its expected result
    task automatic send_frame(input logic [BRIGHT_W-1:0] bright, input logic once,
                              input logic [EXPO_W-1:0] expo, output t_frame_effect effect);
        t_expo_result res;
        if ($urandom_range(99) < send_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_gap_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, expo, bright};
        s_axis_tuser  <= once;
        do @(posedge i_clk); while (!s_axis_tready);
        effect = predict_frame(bright, once, expo, res);
        if (effect == FRAME_CLOSED)
            pending_results.push_back(res);
    endtask

    // Drop valid, wait for all results, then let frames without results drain
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_BRIGHT_LOW:    model_cfg.bright_low    = data[BRIGHT_W-1:0];
            CFG_BRIGHT_HIGH:   model_cfg.bright_high   = data[BRIGHT_W-1:0];
            CFG_BRIGHT_TARGET: model_cfg.bright_target = data[BRIGHT_W-1:0];
            CFG_HYSTERESIS:    model_cfg.hysteresis    = data[HYST_W-1:0];
            CFG_GAIN:          model_cfg.gain          = data[GAIN_W-1:0];
            CFG_EXPO_MIN:      model_cfg.expo_min      = data[EXPO_W-1:0];
            CFG_EXPO_MAX:      model_cfg.expo_max      = data[EXPO_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_settings(input logic [CFG_DATA_W-1:0] low, high, target, hyst,
                                  input logic [CFG_DATA_W-1:0] gain, emin, emax);
        wait_drained();
        write_reg(CFG_BRIGHT_LOW, low);
        write_reg(CFG_BRIGHT_HIGH, high);
        write_reg(CFG_BRIGHT_TARGET, target);
        write_reg(CFG_HYSTERESIS, hyst);
        write_reg(CFG_GAIN, gain);
        write_reg(CFG_EXPO_MIN, emin);
        write_reg(CFG_EXPO_MAX, emax);
    endtask

    // Band edges, inactive frames and field extremes under reset settings
    task automatic test_band_edges();
        t_frame_effect effect;
        send_frame(12'd1000, 1'b0, 16'd1234, effect);
        send_frame(12'd200, 1'b0, 16'd0, effect);
        send_frame(12'd2000, 1'b0, 16'hFFFF, effect);
        send_frame(12'd199, 1'b0, 16'd5000, effect);
        send_frame(12'd2001, 1'b0, 16'd5000, effect);
        send_frame(12'd0, 1'b0, 16'd0, effect);
        send_frame(12'd4095, 1'b0, 16'hFFFF, effect);
        send_frame(12'd1000, 1'b1, 16'd30000, effect);
        send_frame(12'd4095, 1'b1, 16'h5555, effect);
        send_frame(12'd0, 1'b1, 16'hAAAA, effect);
        send_frame(12'd0, 1'b0, 16'd100, effect);
        send_frame(12'd4095, 1'b1, 16'hFFFF, effect);
    endtask

    // Inverted exposure limits force the minimum; stray indexes are ignored
    task automatic test_inverted_limits();
        t_frame_effect effect;
        wait_drained();
        write_reg(CFG_EXPO_MIN, 16'd40000);
        write_reg(CFG_EXPO_MAX, 16'd100);
        write_reg(8'd7, 16'hFFFF);
        write_reg(8'hFF, 16'h0000);
        for (int i = 0; i < 9; i++)
            send_frame((i % 2) ? 12'd4095 : 12'd0, 1'b1, (i % 3) ? 16'hFFFF : 16'd0, effect);
    endtask

    // Random frames, mostly active, some close to the target for the dead band
    task automatic test_random_frames(input int unsigned count);
        int unsigned     sent;
        int              level;
        logic [BRIGHT_W-1:0] bright;
        logic            once;
        logic [EXPO_W-1:0] expo;
        t_frame_effect   effect;
        sent = 0;
        while (sent < count) begin
            case ($urandom_range(9))
                0: begin
                    bright = BRIGHT_W'($urandom_range(4095));
                    once   = 1'b0;
                end
                1: begin
                    bright = $urandom_range(1) ? 12'hFFF : 12'h000;
                    once   = 1'($urandom_range(1));
                end
                2, 3, 4: begin
                    level  = int'($urandom_range(4));
                    level  = int'(model_cfg.bright_target) + level - 2;
                    level  = (level < 0) ? 0 : ((level > 4095) ? 4095 : level);
                    bright = level[BRIGHT_W-1:0];
                    once   = 1'b1;
                end
                default: begin
                    bright = BRIGHT_W'($urandom_range(4095));
                    once   = 1'($urandom_range(1));
                end
            endcase
            case ($urandom_range(5))
                0: expo = 16'd0;
                1: expo = 16'hFFFF;
                default: expo = EXPO_W'($urandom_range(65535));
            endcase
            send_frame(bright, once, expo, effect);
            sent++;
        end
    endtask

    initial begin
        #3000000;
        $display("FAIL auto_exposure_p_control");
        $finish;
    end

    initial begin
        reset_loop_model();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Sender idles lightly, receiver heavily
        send_gap_pct = 30;
        stall_pct    = 73;
        test_band_edges();
        test_inverted_limits();
        write_settings(200, 2000, 500, 10, 2, 0, 65535);
        test_random_frames(75);
        write_settings(1000, 1500, 4095, 32767, 255, 30000, 30000);
        test_random_frames(75);

        // Sender idles heavily, receiver lightly
        send_gap_pct = 73;
        stall_pct    = 30;
        write_settings(4095, 0, 0, 0, 1, 65535, 0);
        test_random_frames(75);
        write_settings(0, 4095, 0, 5, 0, 0, 65535);
        test_random_frames(75);

        // Back to back on both sides
        send_gap_pct = 0;
        stall_pct    = 0;
        write_settings(100, 3000, 2048, 0, 255, 0, 65535);
        test_random_frames(75);
        write_settings(CFG_DATA_W'($urandom_range(4095)), CFG_DATA_W'($urandom_range(4095)),
                       CFG_DATA_W'($urandom_range(4095)), CFG_DATA_W'($urandom_range(32767)),
                       CFG_DATA_W'($urandom_range(255)), CFG_DATA_W'($urandom_range(65535)),
                       CFG_DATA_W'($urandom_range(65535)));
        test_random_frames(75);

        wait_drained();
        if (failed)
            $display("FAIL auto_exposure_p_control");
        else
            $display("PASS auto_exposure_p_control");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/aepc_pkg.sv
hdl/aepc_front.sv
hdl/aepc_queue.sv
hdl/aepc_back.sv
hdl/auto_exposure_p_control.sv
tb/tb_auto_exposure_p_control.sv
